// ===== sv/sshpk_pkg.sv =====
// Package for the SSH public key line parser.
// Holds phase codes, result kinds, status codes and the base64 rank function.
// No dependencies.
package sshpk_pkg;

    localparam int KEYTYPE_MAX = 64;
    localparam int TYPE_DEPTH  = 64;
    localparam int TYPE_AW     = $clog2(TYPE_DEPTH);

    typedef enum logic [3:0] {
        PH_LEAD    = 4'd0,
        PH_HASH    = 4'd1,
        PH_TYPE    = 4'd2,
        PH_GAP     = 4'd3,
        PH_BLOB    = 4'd4,
        PH_REST    = 4'd5,
        PH_COMMENT = 4'd6,
        PH_DONE    = 4'd7
    } t_phase;

    localparam logic [1:0] KIND_KEY     = 2'd0;
    localparam logic [1:0] KIND_COMMENT = 2'd1;
    localparam logic [1:0] KIND_STATUS  = 2'd2;

    localparam logic [2:0] ST_OK         = 3'd0;
    localparam logic [2:0] ST_NO_KEY     = 3'd1;
    localparam logic [2:0] ST_NO_SPACE   = 3'd2;
    localparam logic [2:0] ST_BAD_LEN    = 3'd3;
    localparam logic [2:0] ST_EMPTY      = 3'd4;
    localparam logic [2:0] ST_MISMATCH   = 3'd5;

    localparam logic [7:0] CH_HASH  = 8'h23;
    localparam logic [7:0] CH_LF    = 8'h0a;
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_TAB   = 8'h09;
    localparam logic [7:0] CH_PAD   = 8'h3d;

    // Bit 6 set means the character is not in the alphabet.
    function automatic logic [6:0] b64_rank(input logic [7:0] c);
        logic [6:0] r;
        r = 7'h40;
        if (c >= 8'h41 && c <= 8'h5a) r = {1'b0, 6'(c - 8'h41)};
        else if (c >= 8'h61 && c <= 8'h7a) r = {1'b0, 6'(c - 8'h61 + 8'd26)};
        else if (c >= 8'h30 && c <= 8'h39) r = {1'b0, 6'(c - 8'h30 + 8'd52)};
        else if (c == 8'h2b) r = 7'd62;
        else if (c == 8'h2f) r = 7'd63;
        else if (c == CH_PAD) r = 7'd0;
        return r;
    endfunction

    typedef struct packed {
        logic [1:0] kind;
        logic [7:0] data;
        logic [2:0] status;
        logic       last;
    } t_result;

endpackage

// ===== sv/sshpk_out_fifo.sv =====
// Result queue of the SSH key parser: eight entries of one result each.
// Accepts up to four results per cycle. Depends on sshpk_pkg.
module sshpk_out_fifo (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic [2:0]          i_push_n,
    input  sshpk_pkg::t_result  i_d0,
    input  sshpk_pkg::t_result  i_d1,
    input  sshpk_pkg::t_result  i_d2,
    input  sshpk_pkg::t_result  i_d3,
    output logic [3:0]          o_count,
    output logic                o_valid,
    output sshpk_pkg::t_result  o_head,
    input  logic                i_pop
);
    sshpk_pkg::t_result r_q [8];
    logic [2:0] r_wp, r_rp;
    logic [3:0] r_cnt, n_cnt;
    logic       pop;

    assign pop     = i_pop && (r_cnt != 4'd0);
    assign n_cnt   = r_cnt + {1'b0, i_push_n} - {3'b000, pop};
    assign o_count = r_cnt;
    assign o_valid = r_cnt != 4'd0;
    assign o_head  = r_q[r_rp];

    always_ff @(posedge i_clk) begin
        if (i_push_n >= 3'd1) r_q[r_wp] <= i_d0;
        if (i_push_n >= 3'd2) r_q[r_wp + 3'd1] <= i_d1;
        if (i_push_n >= 3'd3) r_q[r_wp + 3'd2] <= i_d2;
        if (i_push_n == 3'd4) r_q[r_wp + 3'd3] <= i_d3;
        if (!i_rst_n) begin
            r_wp <= '0;
            r_rp <= '0;
            r_cnt <= '0;
        end else begin
            r_wp <= r_wp + i_push_n;
            r_rp <= r_rp + {2'b00, pop};
            r_cnt <= n_cnt;
        end
    end

`ifndef SYNTHESIS
    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ({1'b0, r_cnt} + {2'b00, i_push_n}) <= 5'd8 + {4'd0, pop})
        else $error("result queue overflow");
    a_cnt_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_push_n == 3'd0 && !pop) |=> $stable(r_cnt))
        else $error("count moved without push or pop");
    a_valid_cnt: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid == (r_cnt != 4'd0)))
        else $error("valid disagrees with count");
`endif
endmodule

// ===== sv/sshpk_core.sv =====
// Parser core: phase control, type memory, base64 decode and status.
// Type bytes live in a synchronous RAM read one entry per cycle into a
// three-byte compare window. Depends on sshpk_pkg.
module sshpk_core (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_go,
    input  logic [7:0]          i_byte,
    input  logic                i_last,
    output logic [2:0]          o_push_n,
    output sshpk_pkg::t_result  o_d0,
    output sshpk_pkg::t_result  o_d1,
    output sshpk_pkg::t_result  o_d2,
    output sshpk_pkg::t_result  o_d3
);
    sshpk_pkg::t_phase r_phase, n_phase;
    logic [7:0]  r_mem [sshpk_pkg::TYPE_DEPTH];
    logic [7:0]  r_win [3];
    logic [1:0]  r_slot, n_slot;
    logic [15:0] rsum;
    logic [sshpk_pkg::TYPE_AW-1:0] wa, ra;
    logic [6:0]  r_tlen, n_tlen;
    logic [23:0] r_acc, n_acc;
    logic [1:0]  r_sc, n_sc, r_raw, n_raw, r_pad, n_pad;
    logic [15:0] r_dc, n_dc;
    logic [31:0] r_lp, n_lp;
    logic        r_mis, n_mis_type, n_mis;
    logic [2:0]  r_err, n_err;
    logic        we, blob, cmt, lead_sp;
    logic [6:0]  rk;
    logic [7:0]  bb [3];
    logic        en [3];
    logic [2:0]  st;
    logic [2:0]  np;
    sshpk_pkg::t_result rs [4];

    assign lead_sp = i_byte == sshpk_pkg::CH_SPACE || (i_byte >= 8'h09 && i_byte <= 8'h0d);
    assign rk = sshpk_pkg::b64_rank(i_byte);
    assign wa = r_tlen[sshpk_pkg::TYPE_AW-1:0];

    // Next phase and type write.
    always_comb begin
        n_phase    = r_phase;
        n_tlen     = r_tlen;
        n_mis_type = r_mis;
        n_err      = r_err;
        we   = 1'b0;
        blob = 1'b0;
        cmt  = 1'b0;
        unique case (r_phase)
            sshpk_pkg::PH_LEAD, sshpk_pkg::PH_TYPE: begin
                if (r_phase == sshpk_pkg::PH_LEAD && lead_sp) begin
                    n_phase = r_phase;
                end else if (r_phase == sshpk_pkg::PH_LEAD
                             && i_byte == sshpk_pkg::CH_HASH) begin
                    n_phase = sshpk_pkg::PH_HASH;
                end else if (i_byte == sshpk_pkg::CH_SPACE) begin
                    n_phase = sshpk_pkg::PH_GAP;
                end else if (i_byte == sshpk_pkg::CH_LF) begin
                    n_err = sshpk_pkg::ST_NO_SPACE;
                    n_phase = sshpk_pkg::PH_DONE;
                end else begin
                    n_phase = sshpk_pkg::PH_TYPE;
                    if (r_tlen < 7'(sshpk_pkg::KEYTYPE_MAX)
                        && r_tlen < 7'(sshpk_pkg::TYPE_DEPTH)) begin
                        we = 1'b1;
                        n_tlen = r_tlen + 7'd1;
                    end else begin
                        n_mis_type = 1'b1;
                    end
                end
            end
            sshpk_pkg::PH_HASH: begin
                if (i_byte == sshpk_pkg::CH_LF) n_phase = sshpk_pkg::PH_LEAD;
            end
            sshpk_pkg::PH_GAP: begin
                if (i_byte == sshpk_pkg::CH_SPACE || i_byte == sshpk_pkg::CH_TAB) begin
                    n_phase = r_phase;
                end else if (i_byte == sshpk_pkg::CH_LF) begin
                    n_phase = sshpk_pkg::PH_DONE;
                end else begin
                    n_phase = sshpk_pkg::PH_BLOB;
                    blob = 1'b1;
                end
            end
            sshpk_pkg::PH_BLOB: begin
                if (i_byte == sshpk_pkg::CH_SPACE) n_phase = sshpk_pkg::PH_REST;
                else if (i_byte == sshpk_pkg::CH_LF) n_phase = sshpk_pkg::PH_DONE;
                else blob = 1'b1;
            end
            sshpk_pkg::PH_REST: begin
                if (i_byte == sshpk_pkg::CH_SPACE || i_byte == sshpk_pkg::CH_TAB) begin
                    n_phase = r_phase;
                end else if (i_byte == sshpk_pkg::CH_LF) begin
                    n_phase = sshpk_pkg::PH_DONE;
                end else begin
                    n_phase = sshpk_pkg::PH_COMMENT;
                    cmt = 1'b1;
                end
            end
            sshpk_pkg::PH_COMMENT: begin
                if (i_byte == sshpk_pkg::CH_LF) n_phase = sshpk_pkg::PH_DONE;
                else cmt = 1'b1;
            end
            default: n_phase = r_phase;
        endcase
    end

    // Decode and type compare. The n-th byte of a quad is checked against
    // window slot n, which holds type entry r_dc - 4 + n.
    always_comb begin
        logic [15:0] k;
        logic [1:0]  m;
        n_acc = r_acc; n_sc = r_sc; n_raw = r_raw; n_pad = r_pad;
        n_lp = r_lp; n_mis = n_mis_type;
        en[0] = 1'b0; en[1] = 1'b0; en[2] = 1'b0;
        if (blob) begin
            n_raw = r_raw + 2'd1;
            if (!rk[6]) begin
                n_pad = {r_pad[0], i_byte == sshpk_pkg::CH_PAD};
                n_acc = {r_acc[17:0], rk[5:0]};
                if (r_sc == 2'd3) begin
                    n_sc = 2'd0;
                    en[0] = 1'b1;
                    en[1] = !n_pad[1];
                    en[2] = !n_pad[0];
                end else begin
                    n_sc = r_sc + 2'd1;
                end
            end
        end
        bb[0] = n_acc[23:16]; bb[1] = n_acc[15:8]; bb[2] = n_acc[7:0];
        k = r_dc;
        m = 2'd0;
        for (int i = 0; i < 3; i++) begin
            if (en[i]) begin
                if (k < 16'd4) n_lp = {n_lp[23:0], bb[i]};
                else if (k - 16'd4 < {9'd0, r_tlen} && r_win[m] != bb[i]) n_mis = 1'b1;
                if (k != 16'hffff) k = k + 16'd1;
                m = m + 2'd1;
            end
        end
        n_dc = k;
    end

    always_comb begin
        priority if (n_phase == sshpk_pkg::PH_LEAD || n_phase == sshpk_pkg::PH_HASH)
            st = sshpk_pkg::ST_NO_KEY;
        else if (n_phase == sshpk_pkg::PH_TYPE) st = sshpk_pkg::ST_NO_SPACE;
        else if (n_err != sshpk_pkg::ST_OK) st = n_err;
        else if (n_raw != 2'd0) st = sshpk_pkg::ST_BAD_LEN;
        else if (n_dc == 16'd0) st = sshpk_pkg::ST_EMPTY;
        else if (n_mis || n_dc <= {9'd0, n_tlen} + 16'd4 || n_lp != {25'd0, n_tlen})
            st = sshpk_pkg::ST_MISMATCH;
        else st = sshpk_pkg::ST_OK;
    end

    always_comb begin
        rs[0] = '0; rs[1] = '0; rs[2] = '0; rs[3] = '0;
        np = 3'd0;
        for (int i = 0; i < 3; i++) begin
            if (en[i]) begin
                rs[np[1:0]] = '{kind: sshpk_pkg::KIND_KEY, data: bb[i],
                                status: sshpk_pkg::ST_OK, last: 1'b0};
                np = np + 3'd1;
            end
        end
        if (cmt) begin
            rs[np[1:0]] = '{kind: sshpk_pkg::KIND_COMMENT, data: i_byte,
                            status: sshpk_pkg::ST_OK, last: 1'b0};
            np = np + 3'd1;
        end
        if (i_last) begin
            rs[np[1:0]] = '{kind: sshpk_pkg::KIND_STATUS, data: 8'd0, status: st, last: 1'b1};
            np = np + 3'd1;
        end
    end

    assign o_push_n = i_go ? np : 3'd0;
    assign o_d0 = rs[0];
    assign o_d1 = rs[1];
    assign o_d2 = rs[2];
    assign o_d3 = rs[3];

    // One read a cycle cycles through the three slots. A quad spans four input
    // bytes, so every slot is reloaded from the new r_dc before the next
    // compare. Type writes end before the first quad, and the first quad never
    // compares, so reads and writes of one entry never overlap in use.
    assign rsum = r_dc - 16'd4 + {14'd0, r_slot};
    assign ra = rsum[sshpk_pkg::TYPE_AW-1:0];
    assign n_slot = (r_slot == 2'd2) ? 2'd0 : r_slot + 2'd1;

    always_ff @(posedge i_clk) begin
        if (i_go && we) r_mem[wa] <= i_byte;
        r_win[r_slot] <= r_mem[ra];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_slot <= 2'd0;
        else r_slot <= n_slot;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || (i_go && i_last)) begin
            r_phase <= sshpk_pkg::PH_LEAD;
            r_tlen <= '0; r_acc <= '0; r_sc <= '0; r_raw <= '0; r_pad <= '0;
            r_dc <= '0; r_lp <= '0; r_mis <= 1'b0; r_err <= '0;
        end else if (i_go) begin
            r_phase <= n_phase;
            r_tlen <= n_tlen; r_acc <= n_acc; r_sc <= n_sc; r_raw <= n_raw;
            r_pad <= n_pad; r_dc <= n_dc; r_lp <= n_lp; r_mis <= n_mis;
            r_err <= n_err;
        end
    end

`ifndef SYNTHESIS
    a_status_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_go && i_last) |-> (o_push_n != 3'd0))
        else $error("final beat without status");
    a_reset_after_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_go && i_last) |=> (r_phase == sshpk_pkg::PH_LEAD && r_dc == 16'd0))
        else $error("state not cleared after status");
    a_tlen_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_tlen <= 7'(sshpk_pkg::KEYTYPE_MAX))
        else $error("type length beyond limit");
    a_slot_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_slot != 2'd3)
        else $error("window slot out of range");
`endif
endmodule

// ===== sv/ssh_public_key_line_parser_top.sv =====
// Top level of the SSH public key line parser.
// Instantiates sshpk_core and sshpk_out_fifo; depends on sshpk_pkg.
//
//  channel | dir | handshake         | payload
//  input   | in  | i_valid / o_ready | i_in_byte, i_in_last
//  result  | out | o_valid / i_ready | o_result_kind, o_out_byte, o_parse_status, o_out_last
//
// One text byte is taken per cycle while o_ready is high; each yields zero to
// four results, which are registered into the result queue.
// The rate is set by the eight-entry result queue: input is taken while at
// least four entries are free, so a drained output sustains one byte a cycle.
// Reset is synchronous; no clearing pass. Output stalls back up into o_ready.
module ssh_public_key_line_parser_top (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_valid,
    output logic       o_ready,
    input  logic [7:0] i_in_byte,
    input  logic       i_in_last,
    output logic       o_valid,
    input  logic       i_ready,
    output logic [1:0] o_result_kind,
    output logic [7:0] o_out_byte,
    output logic [2:0] o_parse_status,
    output logic       o_out_last
);
    logic [2:0] push_n;
    logic [3:0] count;
    sshpk_pkg::t_result d0, d1, d2, d3, head;

    assign o_ready = count <= 4'd4;

    sshpk_core u_core (
        .i_clk, .i_rst_n,
        .i_go(i_valid && o_ready),
        .i_byte(i_in_byte), .i_last(i_in_last),
        .o_push_n(push_n), .o_d0(d0), .o_d1(d1), .o_d2(d2), .o_d3(d3)
    );

    sshpk_out_fifo u_fifo (
        .i_clk, .i_rst_n,
        .i_push_n(push_n), .i_d0(d0), .i_d1(d1), .i_d2(d2), .i_d3(d3),
        .o_count(count), .o_valid(o_valid), .o_head(head), .i_pop(i_ready)
    );

    assign o_result_kind  = head.kind;
    assign o_out_byte     = head.data;
    assign o_parse_status = head.status;
    assign o_out_last     = head.last;
endmodule
